### rtl/core/lbf_pkg.sv
`default_nettype none

package lbf_pkg;

	// Channel and word layout
	localparam int NCH       = 5;
	localparam int CH_W      = 8;
	localparam int COLOR_W   = NCH * CH_W;
	localparam int WORD_W    = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 40;

	// Timing constants
	localparam logic [15:0] DEFAULT_TIME = 16'd1000;
	localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;

	// Quotient is capped at 10 bits; anything larger saturates the channel
	localparam int          QUOT_W    = 10;
	localparam logic [3:0]  DIV_STEPS = 4'(QUOT_W);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK  = 3'd4;

	// Phase codes
	localparam logic [2:0] PH_FADE_UP    = 3'd0;
	localparam logic [2:0] PH_HOLD_FULL  = 3'd1;
	localparam logic [2:0] PH_FADE_DOWN  = 3'd2;
	localparam logic [2:0] PH_HOLD_BLACK = 3'd3;
	localparam logic [2:0] PH_FINAL      = 3'd4;

	// Microcode
	typedef logic [2:0] upc_t;

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_DECIDE,
		OP_SETUP,
		OP_DIV,
		OP_CH_END,
		OP_EMIT,
		OP_IDLE
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_ACCEPT,
		C_NO_RAMP,
		C_DIV_MORE,
		C_MORE_CH,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} uword_t;

	typedef struct packed {
		logic accepted;
		logic no_ramp;
		logic div_more;
		logic more_ch;
		logic out_busy;
	} flags_t;

	// Emit sits at the top address so that falling through wraps to wait;
	// the last channel falls into a join step that jumps to emit
	localparam upc_t UPC_WAIT   = 3'd0;
	localparam upc_t UPC_DECIDE = 3'd1;
	localparam upc_t UPC_SETUP  = 3'd2;
	localparam upc_t UPC_DIV    = 3'd3;
	localparam upc_t UPC_CH_END = 3'd4;
	localparam upc_t UPC_JOIN   = 3'd5;
	localparam upc_t UPC_EMIT   = 3'd7;

	function automatic uword_t ucode_rom(input upc_t a);
		uword_t w;
		unique case (a)
			UPC_WAIT:   w = '{op: OP_WAIT,   cond: C_NO_ACCEPT, target: UPC_WAIT};
			UPC_DECIDE: w = '{op: OP_DECIDE, cond: C_NO_RAMP,   target: UPC_EMIT};
			UPC_SETUP:  w = '{op: OP_SETUP,  cond: C_NEXT,      target: UPC_WAIT};
			UPC_DIV:    w = '{op: OP_DIV,    cond: C_DIV_MORE,  target: UPC_DIV};
			UPC_CH_END: w = '{op: OP_CH_END, cond: C_MORE_CH,   target: UPC_SETUP};
			UPC_JOIN:   w = '{op: OP_IDLE,   cond: C_ALWAYS,    target: UPC_EMIT};
			UPC_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_BUSY,  target: UPC_EMIT};
			default:    w = '{op: OP_WAIT,   cond: C_ALWAYS,    target: UPC_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

### rtl/core/lbf_sequencer.sv
`default_nettype none

module lbf_sequencer (
	input  wire              clk,
	input  wire              arst_n,
	input  lbf_pkg::flags_t  flags,
	output lbf_pkg::uword_t  cw
);
	import lbf_pkg::*;

	upc_t upc_q;
	logic take;

	assign cw = ucode_rom(upc_q);

	always_comb begin
		unique case (cw.cond)
			C_NEXT:      take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_ACCEPT: take = !flags.accepted;
			C_NO_RAMP:   take = flags.no_ramp;
			C_DIV_MORE:  take = flags.div_more;
			C_MORE_CH:   take = flags.more_ch;
			C_OUT_BUSY:  take = flags.out_busy;
			default:     take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_WAIT;
		end else if (take) begin
			upc_q <= cw.target;
		end else begin
			upc_q <= upc_q + 3'd1;
		end
	end

endmodule

`default_nettype wire

### rtl/core/lbf_datapath.sv
`default_nettype none

module lbf_datapath (
	input  wire                                clk,
	input  wire                                arst_n,
	input  lbf_pkg::uword_t                    cw,
	output lbf_pkg::flags_t                    flags,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [lbf_pkg::WORD_W-1:0]         s_tdata,
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [lbf_pkg::WORD_W-1:0]         m_tdata,
	input  wire                                cfg_we,
	input  wire  [lbf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [lbf_pkg::CFG_W-1:0]          cfg_data
);
	import lbf_pkg::*;

	typedef enum logic [2:0] {
		K_TARGET,
		K_BLACK,
		K_UP,
		K_DOWN,
		K_FIN_BLEND,
		K_FIN_BLACK
	} kind_t;

	// Configuration
	logic [COLOR_W-1:0] target_q, start_q;
	logic [15:0]        fade_q, hold_q;
	logic [7:0]         blink_q;

	// Sequencer state
	logic [2:0]  phase_q;
	logic [16:0] elapsed_q;
	logic [7:0]  cycles_q;
	logic        use_start_q;

	// Per-word working registers
	logic [CH_W-1:0] resume_q [NCH];
	logic [CH_W-1:0] col_q [NCH];
	kind_t           kind_q;
	logic            moved_q, done_q;
	logic [2:0]      phase_out_q;
	logic [2:0]      ch_q;

	// Divider
	logic [15:0]       rem_q;
	logic [QUOT_W-1:0] nq_q;
	logic [3:0]        cnt_q;
	logic              neg_q, ovf_q;
	logic [CH_W-1:0]   base_q;

	logic              m_tvalid_q;
	logic [WORD_W-1:0] m_tdata_q;

	logic [15:0] ft, ht;
	logic        accepted, out_busy;

	assign ft = (fade_q == 16'd0) ? DEFAULT_TIME : fade_q;
	assign ht = (hold_q == 16'd0) ? DEFAULT_TIME : hold_q;

	assign s_tready = (cw.op == OP_WAIT);
	assign accepted = s_tvalid && s_tready;
	assign out_busy = m_tvalid_q && !m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Phase decision for this tick
	kind_t      kind_d;
	logic [2:0] phase_n, phase_out_d;
	logic       moved_d, done_d, usc_n;
	logic [7:0] cyc_n, cyc_inc;
	logic       e_gt_ft, e_gt_ht, single;

	assign e_gt_ft = elapsed_q > {1'b0, ft};
	assign e_gt_ht = elapsed_q > {1'b0, ht};
	assign single  = blink_q <= 8'd1;
	assign cyc_inc = (cycles_q != 8'hFF) ? cycles_q + 8'd1 : cycles_q;

	always_comb begin
		kind_d      = K_TARGET;
		phase_n     = phase_q;
		phase_out_d = phase_q;
		moved_d     = 1'b0;
		done_d      = 1'b0;
		cyc_n       = cycles_q;
		usc_n       = use_start_q;
		unique case (phase_q)
			PH_FADE_UP: begin
				if (e_gt_ft) begin
					phase_n = PH_HOLD_FULL;
					usc_n   = 1'b0;
					moved_d = 1'b1;
				end else begin
					kind_d = K_UP;
				end
			end
			PH_HOLD_FULL: begin
				if (e_gt_ht) begin
					phase_n = PH_FADE_DOWN;
					moved_d = 1'b1;
				end
			end
			PH_FADE_DOWN: begin
				if (single) begin
					phase_n = PH_FINAL;
					moved_d = 1'b1;
				end else if (e_gt_ft) begin
					kind_d  = K_BLACK;
					phase_n = PH_HOLD_BLACK;
					moved_d = 1'b1;
				end else begin
					kind_d = K_DOWN;
				end
			end
			PH_HOLD_BLACK: begin
				kind_d = K_BLACK;
				if (e_gt_ht) begin
					cyc_n   = cyc_inc;
					phase_n = (cyc_inc >= blink_q) ? PH_FINAL : PH_FADE_UP;
					moved_d = 1'b1;
				end
			end
			default: begin
				// unreachable codes above final behave as final
				phase_out_d = PH_FINAL;
				kind_d      = single ? K_FIN_BLEND : K_FIN_BLACK;
				done_d      = e_gt_ft;
			end
		endcase
	end

	assign flags.accepted = accepted;
	assign flags.no_ramp  = (kind_d == K_TARGET) || (kind_d == K_BLACK);
	assign flags.div_more = (cnt_q != 4'd1);
	assign flags.more_ch  = (ch_q != 3'(NCH - 1));
	assign flags.out_busy = out_busy;

	// Channel setup: base, signed difference, |e*diff| and overflow check
	logic [5:0]       ch_off;
	logic [CH_W-1:0]  tgt_c, st_c, rs_c, base_c;
	logic signed [9:0] diff_c;
	logic [CH_W-1:0]  mag_c;
	logic [24:0]      prod_c;
	logic             ovf_c;

	assign ch_off = {ch_q, 3'b000};
	assign tgt_c  = target_q[ch_off +: CH_W];
	assign st_c   = start_q[ch_off +: CH_W];
	assign rs_c   = resume_q[ch_q];

	always_comb begin
		base_c = '0;
		diff_c = '0;
		unique case (kind_q)
			K_UP: begin
				base_c = use_start_q ? st_c : '0;
				diff_c = $signed({2'b00, tgt_c}) - $signed({2'b00, base_c});
			end
			K_DOWN: begin
				base_c = tgt_c;
				diff_c = -$signed({2'b00, tgt_c});
			end
			K_FIN_BLEND: begin
				base_c = tgt_c;
				diff_c = $signed({2'b00, rs_c}) - $signed({2'b00, tgt_c});
			end
			K_FIN_BLACK: begin
				base_c = '0;
				diff_c = $signed({2'b00, rs_c});
			end
			default: begin
				base_c = '0;
				diff_c = '0;
			end
		endcase
	end

	logic [9:0] diff_abs;
	assign diff_abs = diff_c[9] ? 10'(-diff_c) : 10'(diff_c);
	assign mag_c    = diff_abs[CH_W-1:0];
	assign prod_c   = 25'(elapsed_q) * 25'(mag_c);
	assign ovf_c    = {1'b0, prod_c} >= {ft, 10'd0};

	// Restoring divide step
	logic [16:0] trial;
	logic        ge;
	logic [15:0] rem_n;

	assign trial = {rem_q, nq_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, ft};
	assign rem_n = ge ? 16'(trial - {1'b0, ft}) : trial[15:0];

	// Channel finish: apply sign, add base, saturate to 0..255
	logic signed [11:0] qs, sum;
	logic [CH_W-1:0]    sat_c;

	assign qs  = neg_q ? -$signed({2'b00, nq_q}) : $signed({2'b00, nq_q});
	assign sum = $signed({4'b0000, base_q}) + qs;

	always_comb begin
		if (ovf_q) begin
			sat_c = neg_q ? 8'h00 : 8'hFF;
		end else if (sum < 0) begin
			sat_c = 8'h00;
		end else if (sum > 12'sd255) begin
			sat_c = 8'hFF;
		end else begin
			sat_c = sum[CH_W-1:0];
		end
	end

	logic [COLOR_W-1:0] col_flat;
	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			col_flat[i*CH_W +: CH_W] = col_q[i];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			start_q  <= '0;
			fade_q   <= DEFAULT_TIME;
			hold_q   <= DEFAULT_TIME;
			blink_q  <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET: target_q <= cfg_data;
				REG_START:  start_q  <= cfg_data;
				REG_FADE:   fade_q   <= cfg_data[15:0];
				REG_HOLD:   hold_q   <= cfg_data[15:0];
				REG_BLINK:  blink_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FADE_UP;
			elapsed_q   <= '0;
			cycles_q    <= '0;
			use_start_q <= 1'b1;
			ch_q        <= '0;
			cnt_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			// emit handles its own handoff below
			if (m_tvalid_q && m_tready && (cw.op != OP_EMIT)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (cw.op)
				OP_WAIT: begin
					if (accepted && s_tdata[0]) begin
						phase_q     <= PH_FADE_UP;
						elapsed_q   <= '0;
						cycles_q    <= '0;
						use_start_q <= 1'b1;
					end
				end
				OP_DECIDE: begin
					phase_q     <= phase_n;
					cycles_q    <= cyc_n;
					use_start_q <= usc_n;
					ch_q        <= '0;
				end
				OP_SETUP: begin
					cnt_q <= DIV_STEPS;
				end
				OP_DIV: begin
					cnt_q <= cnt_q - 4'd1;
				end
				OP_CH_END: begin
					ch_q <= ch_q + 3'd1;
				end
				OP_EMIT: begin
					if (!out_busy) begin
						m_tvalid_q <= 1'b1;
						if (moved_q) begin
							elapsed_q <= 17'd1;
						end else if (elapsed_q != ELAPSED_MAX) begin
							elapsed_q <= elapsed_q + 17'd1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_WAIT: begin
				if (accepted) begin
					for (int i = 0; i < NCH; i++) begin
						resume_q[i] <= s_tdata[1 + i*CH_W +: CH_W];
					end
				end
			end
			OP_DECIDE: begin
				kind_q      <= kind_d;
				moved_q     <= moved_d;
				done_q      <= done_d;
				phase_out_q <= phase_out_d;
				for (int i = 0; i < NCH; i++) begin
					col_q[i] <= (kind_d == K_TARGET) ? target_q[i*CH_W +: CH_W] : '0;
				end
			end
			OP_SETUP: begin
				base_q <= base_c;
				neg_q  <= diff_c[9];
				ovf_q  <= ovf_c;
				rem_q  <= 16'(prod_c[24:QUOT_W]);
				nq_q   <= prod_c[QUOT_W-1:0];
			end
			OP_DIV: begin
				rem_q <= rem_n;
				nq_q  <= {nq_q[QUOT_W-2:0], ge};
			end
			OP_CH_END: begin
				col_q[ch_q] <= sat_c;
			end
			OP_EMIT: begin
				if (!out_busy) begin
					m_tdata_q <= {4'b0000, done_q, phase_out_q, col_flat};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/led_blink_fade_sequencer_top.sv
// Each accepted tick is worked through in turn; the next tick is accepted only after emit.
// A ramping tick runs decide, per channel setup, ten divide steps and finish, a join step
// and emit; a hold tick runs decide and emit. A stalled output holds the program in emit
// until the word leaves; the finished word waits in the output register while the next
// word is accepted. The divide steps are those of the serial restoring divider.
// Reset (arst_n low, asynchronous): config to defaults, phase fade up, counters zero.
`default_nettype none

module led_blink_fade_sequencer_top (
	input  wire                            clk,
	input  wire                            arst_n,
	// s_tdata: restart[0], resume_r[8:1], resume_g[16:9], resume_b[24:17],
	//          resume_cw[32:25], resume_ww[40:33], zero[47:41]
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire  [lbf_pkg::WORD_W-1:0]     s_tdata,
	// m_tdata: out_r[7:0], out_g[15:8], out_b[23:16], out_cw[31:24],
	//          out_ww[39:32], phase[42:40], done_res[43], zero[47:44]
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [lbf_pkg::WORD_W-1:0]     m_tdata,
	// register writes: 0 target, 1 start, 2 fade time, 3 hold time, 4 blink count
	input  wire                            cfg_we,
	input  wire  [lbf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [lbf_pkg::CFG_W-1:0]      cfg_data
);
	import lbf_pkg::*;

	// Microcode program: wait -> decide -> (setup, divide x10, finish) x5 -> join -> emit.
	// Hold phases and phase exits branch from decide straight to emit.
	// Reset also re-arms the start colour and empties the output register.
	uword_t cw;
	flags_t flags;

	lbf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.cw     (cw)
	);

	// Datapath: config regs, phase state, one multiplier and a restoring divider
	// shared by the five channels, channel results and the output register.
	lbf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cw        (cw),
		.flags     (flags),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

`default_nettype wire

### verif/tb_led_blink_fade_sequencer_top.sv
`timescale 1ns / 1ps

module tb_led_blink_fade_sequencer_top;
	import lbf_pkg::*;

	// Output word layout: five channels in the low bytes, then phase, then done
	localparam int PHASE_LSB     = COLOR_W;
	localparam int DONE_BIT      = COLOR_W + 3;
	// Longest legal stretch without any handshake is one ramp tick plus a sender
	// gap plus receiver stalls; allow far more
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 80;
	localparam int RANDOM_TICKS  = 640;

	typedef logic [NCH-1:0][CH_W-1:0] color_t;

	typedef struct packed {
		color_t     col;
		logic [2:0] phase;
		logic       done;
	} lamp_word_t;

	// Tracks the sequencer's registers and state, predicts one lamp word per
	// accepted tick and checks the words that come out in order.
	class lamp_scoreboard;
		color_t      target_col;
		color_t      start_col;
		logic [15:0] fade_len;
		logic [15:0] hold_len;
		logic [7:0]  blink_total;

		logic [2:0]  ph;
		logic [16:0] elapsed;
		logic [7:0]  blinks_done;
		bit          from_start;

		lamp_word_t  expected_lamps[$];
		int unsigned ticks;
		int unsigned checked;
		int unsigned mismatches;
		int unsigned done_words;
		int unsigned phase_words[5];
		string       chan_label[NCH];

		function new();
			target_col  = '0;
			start_col   = '0;
			fade_len    = DEFAULT_TIME;
			hold_len    = DEFAULT_TIME;
			blink_total = 8'd1;
			ph          = PH_FADE_UP;
			elapsed     = '0;
			blinks_done = '0;
			from_start  = 1'b1;
			chan_label  = '{"out_r", "out_g", "out_b", "out_cw", "out_ww"};
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_TARGET: target_col  = data;
				REG_START:  start_col   = data;
				REG_FADE:   fade_len    = data[15:0];
				REG_HOLD:   hold_len    = data[15:0];
				REG_BLINK:  blink_total = data[7:0];
				default: ;
			endcase
		endfunction

		// base + e*diff/len, truncated toward zero, clamped to a byte
		function logic [7:0] ramp(longint base, longint diff, longint e, longint len);
			longint v;
			v = base + (e * diff) / len;
			if (v < 0)
				return 8'd0;
			if (v > 255)
				return 8'd255;
			return v[7:0];
		endfunction

		function void accept_tick(logic restart, color_t resume);
			longint     ft;
			longint     ht;
			longint     e;
			longint     base;
			longint     tc;
			logic [2:0] cur;
			bit         moved;
			lamp_word_t want;
			ft = (fade_len == 0) ? longint'(DEFAULT_TIME) : longint'(fade_len);
			ht = (hold_len == 0) ? longint'(DEFAULT_TIME) : longint'(hold_len);
			want = '0;
			moved = 1'b0;
			if (restart) begin
				ph          = PH_FADE_UP;
				elapsed     = '0;
				blinks_done = '0;
				from_start  = 1'b1;
			end
			cur = ph;
			e = longint'(elapsed);
			case (cur)
				PH_FADE_UP: begin
					if (e > ft) begin
						want.col   = target_col;
						ph         = PH_HOLD_FULL;
						from_start = 1'b0;
						moved      = 1'b1;
					end else begin
						for (int c = 0; c < NCH; c++) begin
							base = from_start ? longint'(start_col[c]) : 0;
							want.col[c] = ramp(base, longint'(target_col[c]) - base, e, ft);
						end
					end
				end
				PH_HOLD_FULL: begin
					want.col = target_col;
					if (e > ht) begin
						ph    = PH_FADE_DOWN;
						moved = 1'b1;
					end
				end
				PH_FADE_DOWN: begin
					if (blink_total <= 1) begin
						// single blink: no fade down, straight to the final ramp
						want.col = target_col;
						ph       = PH_FINAL;
						moved    = 1'b1;
					end else if (e > ft) begin
						ph    = PH_HOLD_BLACK;
						moved = 1'b1;
					end else begin
						for (int c = 0; c < NCH; c++) begin
							tc = longint'(target_col[c]);
							want.col[c] = ramp(tc, -tc, e, ft);
						end
					end
				end
				PH_HOLD_BLACK: begin
					if (e > ht) begin
						if (blinks_done < 8'd255)
							blinks_done++;
						ph    = (blinks_done >= blink_total) ? PH_FINAL : PH_FADE_UP;
						moved = 1'b1;
					end
				end
				default: begin
					for (int c = 0; c < NCH; c++) begin
						tc = longint'(target_col[c]);
						if (blink_total <= 1)
							want.col[c] = ramp(tc, longint'(resume[c]) - tc, e, ft);
						else
							want.col[c] = ramp(0, longint'(resume[c]), e, ft);
					end
					want.done = (e > ft);
				end
			endcase
			if (moved)
				elapsed = 17'd1;
			else if (elapsed < ELAPSED_MAX)
				elapsed++;
			want.phase = (cur > PH_FINAL) ? PH_FINAL : cur;
			expected_lamps.push_back(want);
			ticks++;
		endfunction

		function void check_lamp(logic [WORD_W-1:0] w);
			lamp_word_t want;
			color_t     got;
			if (expected_lamps.size() == 0) begin
				mismatches++;
				$error("lamp word %h arrived with no tick pending", w);
				return;
			end
			want = expected_lamps.pop_front();
			got = w[COLOR_W-1:0];
			for (int c = 0; c < NCH; c++)
				if (got[c] !== want.col[c]) begin
					mismatches++;
					$error("%s: expected %0d, got %0d", chan_label[c], want.col[c], got[c]);
				end
			if (w[DONE_BIT-1:PHASE_LSB] !== want.phase) begin
				mismatches++;
				$error("phase: expected %0d, got %0d", want.phase, w[DONE_BIT-1:PHASE_LSB]);
			end
			if (w[DONE_BIT] !== want.done) begin
				mismatches++;
				$error("done_res: expected %0d, got %0d", want.done, w[DONE_BIT]);
			end
			if (w[WORD_W-1:DONE_BIT+1] !== '0) begin
				mismatches++;
				$error("pad: expected 0, got %h", w[WORD_W-1:DONE_BIT+1]);
			end
			checked++;
			phase_words[want.phase]++;
			if (want.done)
				done_words++;
		endfunction

		function int unsigned pending();
			return expected_lamps.size();
		endfunction
	endclass

	// Block ports; every input starts at a known value
	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [WORD_W-1:0]    s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [WORD_W-1:0]    m_tdata;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	lamp_scoreboard sb = new();

	// tx_calm / rx_calm switch off random idling on the sender / receiver side
	bit          tx_calm = 1'b0;
	logic        rx_calm = 1'b0;
	int unsigned settings_used = 0;
	int unsigned quiet_cycles = 0;

	led_blink_fade_sequencer_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Receiver: ready most of the time, short random stalls unless calm
	always @(posedge clk)
		m_tready <= rx_calm || ($urandom_range(99) >= 6);

	// Every accepted lamp word goes against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_lamp(m_tdata);
	end

	// Watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("No handshake for %0d cycles, %0d lamp words outstanding",
				quiet_cycles, sb.pending());
			$display("Verification failed");
			$finish;
		end
	end

	function automatic color_t rand_color();
		color_t col;
		case ($urandom_range(7))
			0: col = '0;
			1: col = '1;
			default: begin
				for (int i = 0; i < NCH; i++)
					col[i] = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00)
						: 8'($urandom);
			end
		endcase
		return col;
	endfunction

	// One register write per call; the caller lowers cfg_we after the last one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
	endtask

	// All five registers, with junk above each narrow register's width;
	// sometimes an unused index too, which must change nothing
	task automatic write_settings(input color_t target, input color_t start,
			input logic [15:0] fade, input logic [15:0] hold, input logic [7:0] blinks);
		write_reg(REG_TARGET, target);
		write_reg(REG_START, start);
		write_reg(REG_FADE, {24'($urandom), fade});
		write_reg(REG_HOLD, {24'($urandom), hold});
		write_reg(REG_BLINK, {32'($urandom), blinks});
		if ($urandom_range(3) == 0)
			write_reg(REG_BLINK + 3'($urandom_range(1, 3)), 40'({$urandom, $urandom}));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic random_settings();
		logic [15:0] fade;
		logic [15:0] hold;
		logic [7:0]  blinks;
		case ($urandom_range(9))
			0: fade = '0;
			1: fade = 16'hFFFF;
			2: fade = 16'($urandom_range(7, 40));
			default: fade = 16'($urandom_range(1, 6));
		endcase
		case ($urandom_range(9))
			0: hold = '0;
			1: hold = 16'hFFFF;
			2: hold = 16'($urandom_range(6, 30));
			default: hold = 16'($urandom_range(1, 5));
		endcase
		case ($urandom_range(7))
			0: blinks = 8'hFF;
			1: blinks = 8'($urandom_range(4, 254));
			default: blinks = 8'($urandom_range(0, 3));
		endcase
		write_settings(rand_color(), rand_color(), fade, hold, blinks);
	endtask

	// Sends one tick word; occasionally holds off first so gaps land on every
	// stage of the block's serial divide. Leaves tvalid high after acceptance.
	task automatic send_tick(input logic restart, input color_t resume);
		if (!tx_calm && $urandom_range(99) < 6) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 70)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= WORD_W'({resume, restart});
		do begin
			@(posedge clk);
		end while (!s_tready);
		sb.accept_tick(restart, resume);
	endtask

	// Sender pauses until every predicted lamp word has come back
	task automatic drain_lamps();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned random_ticks;
		int unsigned n;
		random_ticks = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single blink with fade length 2 (odd differences truncate
		// toward zero), then fade-down skip and final ramp from target to
		// alternating all-off / all-on resume colours
		write_settings(40'hFF_01_80_FF_00, 40'h00_FF_7F_00_FF, 16'd2, 16'd1, 8'd0);
		for (int i = 0; i < 10; i++)
			send_tick(i == 0, (i % 2) ? color_t'('1) : color_t'('0));
		drain_lamps();

		// Directed: two blinks, second fade up starts from black, final ramps
		// from black to the resume colour and raises done
		write_settings(40'h80_FF_00_FF_01, 40'hFF_00_FF_00_FF, 16'd1, 16'd1, 8'd2);
		for (int i = 0; i < 19; i++)
			send_tick(i == 0, rand_color());

		// Random settings, mostly short times so the sequence reaches the
		// final phase; each run opens with a restart about half the time
		while (random_ticks < RANDOM_TICKS) begin
			drain_lamps();
			tx_calm = (settings_used % 8) == 5;
			rx_calm <= (settings_used % 8) == 5;
			random_settings();
			n = $urandom_range(15, 60);
			for (int i = 0; i < n; i++)
				send_tick((i == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3),
					rand_color());
			random_ticks += n;
		end

		// Zero times stand for 1000 ticks; blink count zero
		drain_lamps();
		tx_calm = 1'b0;
		rx_calm <= 1'b0;
		write_settings('1, '0, 16'd0, 16'd0, 8'd0);
		for (int i = 0; i < 20; i++)
			send_tick(i == 0, rand_color());

		// Longest fade from an all-on start colour
		drain_lamps();
		write_settings(rand_color(), '1, 16'hFFFF, 16'hFFFF, 8'd1);
		for (int i = 0; i < 20; i++)
			send_tick(i == 0, rand_color());

		// Twenty blink cycles back to back, no idling on either side
		drain_lamps();
		tx_calm = 1'b1;
		rx_calm <= 1'b1;
		write_settings(rand_color(), rand_color(), 16'd1, 16'd1, 8'd20);
		send_tick(1'b1, rand_color());
		while (sb.ph != PH_FINAL)
			send_tick(1'b0, rand_color());
		repeat (3) send_tick(1'b0, rand_color());

		// Long hold: a hold time of a hundred ticks at full before fade down
		drain_lamps();
		tx_calm = 1'b0;
		rx_calm <= 1'b0;
		write_settings(rand_color(), rand_color(), 16'd1, 16'd100, 8'd2);
		send_tick(1'b1, rand_color());
		while (sb.ph != PH_FADE_DOWN)
			send_tick(1'b0, rand_color());
		repeat (3) send_tick(1'b0, rand_color());

		drain_lamps();
		repeat (END_CYCLES) @(posedge clk);

		$display("Ran %0d ticks over %0d register settings, times 0 to 65535, blink counts 0 to 255",
			sb.ticks, settings_used);
		$display("Words per phase: fade up %0d, hold full %0d, fade down %0d,",
			sb.phase_words[PH_FADE_UP], sb.phase_words[PH_HOLD_FULL],
			sb.phase_words[PH_FADE_DOWN]);
		$display("  hold black %0d, final %0d (%0d done)",
			sb.phase_words[PH_HOLD_BLACK], sb.phase_words[PH_FINAL], sb.done_words);
		if (sb.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
